[rtl/acv_pkg.sv]
// shared types and constants of the acl canonical order validator
package acv_pkg;

    // entry tag codes
    typedef enum logic [2:0] {
        TAG_OWNER       = 3'd0,
        TAG_NAMED_USER  = 3'd1,
        TAG_OWNER_GROUP = 3'd2,
        TAG_NAMED_GROUP = 3'd3,
        TAG_MASK        = 3'd4,
        TAG_OTHER       = 3'd5
    } t_tag;

    localparam int TAG_W   = 3;
    localparam int PERM_W  = 16;
    localparam int ID_W    = 32;
    localparam int COUNT_W = 6;

    localparam logic [PERM_W-1:0] PERM_ALLOWED = 16'h0007;
    localparam logic [ID_W-1:0]   UNDEF_ID     = 32'hFFFF_FFFF;
    localparam int                MIN_ENTRIES  = 3;

    // one acl entry word
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PERM_W-1:0] perm;
        logic [ID_W-1:0]   id;
        logic              last;
    } t_entry;

    // verdict for one list
    typedef struct packed {
        logic               acl_valid;
        logic [COUNT_W-1:0] entry_count;
    } t_verdict;

endpackage

[rtl/acl_canonical_validator_top.sv]
// top level of the acl canonical order validator
// One acl entry word is taken per cycle unless the input stalls, and checked against the
// canonical order (owner, ascending named users, owning group, ascending named groups,
// optional mask, other) and the permission and length rules. Each word is held in the
// input register and checked on its way to the result register, so a word can follow in
// every cycle; the word with i_last_entry set yields one verdict word in the result
// register, and all other words yield none. The input stalls only while a last word waits
// for a result register that is still full and stalled downstream. o_entry_count carries
// the low six bits of the entry count, which saturates at MAX_ENTRIES plus one.
module acl_canonical_validator_top #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [acv_pkg::TAG_W-1:0]    i_entry_tag,
    input  logic [acv_pkg::PERM_W-1:0]   i_entry_perm,
    input  logic [acv_pkg::ID_W-1:0]     i_entry_id,
    input  logic                         i_last_entry,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_acl_valid,
    output logic [acv_pkg::COUNT_W-1:0]  o_entry_count
);
    import acv_pkg::*;

    t_entry   in_entry;
    t_entry   cur_entry;
    t_verdict verdict;
    t_verdict out_verdict;
    logic     cur_valid;
    logic     out_free;
    logic     move;

    assign in_entry.tag  = i_entry_tag;
    assign in_entry.perm = i_entry_perm;
    assign in_entry.id   = i_entry_id;
    assign in_entry.last = i_last_entry;

    // a non-last word never needs the result register
    assign move = cur_valid && (!cur_entry.last || out_free);

    acv_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_entry (in_entry),
        .i_move  (move),
        .o_valid (cur_valid),
        .o_entry (cur_entry)
    );

    acv_rules #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_rules (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (move),
        .i_entry   (cur_entry),
        .o_verdict (verdict)
    );

    acv_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (move && cur_entry.last),
        .i_verdict (verdict),
        .o_free    (out_free),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_verdict (out_verdict)
    );

    assign o_acl_valid   = out_verdict.acl_valid;
    assign o_entry_count = out_verdict.entry_count;

endmodule

[rtl/acv_in_reg.sv]
// input register stage holding one entry word
module acv_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  acv_pkg::t_entry i_entry,
    input  logic            i_move,
    output logic            o_valid,
    output acv_pkg::t_entry o_entry
);
    import acv_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    logic   accept;

    // hold off the sender only while a word sits here and cannot move on
    assign o_stall = r_valid && !i_move;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_move) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= i_entry;
        end
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;

endmodule

[rtl/acv_rules.sv]
// order rules, list state and verdict for each entry word
module acv_rules #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  acv_pkg::t_entry   i_entry,
    output acv_pkg::t_verdict o_verdict
);
    import acv_pkg::*;

    localparam int                IDX_W   = $clog2(MAX_ENTRIES + 2);
    localparam logic [IDX_W-1:0]  IDX_SAT = IDX_W'(MAX_ENTRIES + 1);
    localparam logic [IDX_W-1:0]  IDX_MAX = IDX_W'(MAX_ENTRIES);
    localparam logic [IDX_W-1:0]  IDX_MIN = IDX_W'(MIN_ENTRIES);

    logic [IDX_W-1:0] r_index,      n_index;
    logic             r_seen_owner, n_seen_owner;
    logic             r_seen_group, n_seen_group;
    logic             r_seen_mask,  n_seen_mask;
    logic             r_seen_other, n_seen_other;
    logic             r_any_user,   n_any_user;
    logic             r_any_group,  n_any_group;
    logic [ID_W-1:0]  r_prev_user,  n_prev_user;
    logic [ID_W-1:0]  r_prev_group, n_prev_group;
    logic             r_error,      n_error;
    logic             bad;
    logic [IDX_W+COUNT_W-1:0] count_ext;

    always_comb begin
        n_seen_owner = r_seen_owner;
        n_seen_group = r_seen_group;
        n_seen_mask  = r_seen_mask;
        n_seen_other = r_seen_other;
        n_any_user   = r_any_user;
        n_any_group  = r_any_group;
        n_prev_user  = r_prev_user;
        n_prev_group = r_prev_group;
        bad          = 1'b0;

        if ((i_entry.perm & ~PERM_ALLOWED) != '0) begin
            bad = 1'b1;
        end else begin
            case (i_entry.tag)
                TAG_OWNER: begin
                    if (r_seen_owner || r_index != '0) begin
                        bad = 1'b1;
                    end else begin
                        n_seen_owner = 1'b1;
                    end
                end
                TAG_NAMED_USER: begin
                    if (!r_seen_owner || r_seen_group || i_entry.id == UNDEF_ID ||
                        (r_any_user && i_entry.id <= r_prev_user)) begin
                        bad = 1'b1;
                    end else begin
                        n_prev_user = i_entry.id;
                        n_any_user  = 1'b1;
                    end
                end
                TAG_OWNER_GROUP: begin
                    if (!r_seen_owner || r_seen_group) begin
                        bad = 1'b1;
                    end else begin
                        n_seen_group = 1'b1;
                    end
                end
                TAG_NAMED_GROUP: begin
                    if (!r_seen_group || r_seen_mask || i_entry.id == UNDEF_ID ||
                        (r_any_group && i_entry.id <= r_prev_group)) begin
                        bad = 1'b1;
                    end else begin
                        n_prev_group = i_entry.id;
                        n_any_group  = 1'b1;
                    end
                end
                TAG_MASK: begin
                    if (r_seen_mask || !r_seen_group) begin
                        bad = 1'b1;
                    end else begin
                        n_seen_mask = 1'b1;
                    end
                end
                TAG_OTHER: begin
                    if (r_seen_other || !r_seen_group || !i_entry.last) begin
                        bad = 1'b1;
                    end else begin
                        n_seen_other = 1'b1;
                    end
                end
                default: begin
                    bad = 1'b1;
                end
            endcase
        end

        n_error = r_error || bad;
        n_index = (r_index < IDX_SAT) ? r_index + 1'b1 : r_index;
    end

    // verdict is built from the state as it stands after this entry
    assign count_ext             = {{COUNT_W{1'b0}}, n_index};
    assign o_verdict.entry_count = count_ext[COUNT_W-1:0];
    assign o_verdict.acl_valid   = !n_error && n_index >= IDX_MIN && n_index <= IDX_MAX &&
                                   n_seen_owner && n_seen_group && n_seen_other &&
                                   (!(n_any_user || n_any_group) || n_seen_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index      <= '0;
            r_seen_owner <= 1'b0;
            r_seen_group <= 1'b0;
            r_seen_mask  <= 1'b0;
            r_seen_other <= 1'b0;
            r_any_user   <= 1'b0;
            r_any_group  <= 1'b0;
            r_prev_user  <= '0;
            r_prev_group <= '0;
            r_error      <= 1'b0;
        end else if (i_fire) begin
            if (i_entry.last) begin
                r_index      <= '0;
                r_seen_owner <= 1'b0;
                r_seen_group <= 1'b0;
                r_seen_mask  <= 1'b0;
                r_seen_other <= 1'b0;
                r_any_user   <= 1'b0;
                r_any_group  <= 1'b0;
                r_prev_user  <= '0;
                r_prev_group <= '0;
                r_error      <= 1'b0;
            end else begin
                r_index      <= n_index;
                r_seen_owner <= n_seen_owner;
                r_seen_group <= n_seen_group;
                r_seen_mask  <= n_seen_mask;
                r_seen_other <= n_seen_other;
                r_any_user   <= n_any_user;
                r_any_group  <= n_any_group;
                r_prev_user  <= n_prev_user;
                r_prev_group <= n_prev_group;
                r_error      <= n_error;
            end
        end
    end

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= IDX_SAT)
        else $error("entry index beyond saturation");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_entry.last) |=> (r_index == '0 && !r_error && !r_seen_owner))
        else $error("list state not cleared after last word");

    a_mask_after_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_mask |-> r_seen_group)
        else $error("mask recorded without owning group");

    a_named_group_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any_group |-> r_seen_group)
        else $error("named group recorded without owning group");

    a_named_user_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any_user |-> r_seen_owner)
        else $error("named user recorded without owner");

endmodule

[rtl/acv_out_reg.sv]
// result register holding one verdict word
module acv_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  acv_pkg::t_verdict i_verdict,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output acv_pkg::t_verdict o_verdict
);
    import acv_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_verdict r_verdict;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_verdict <= i_verdict;
        end
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;

endmodule

[verif/acl_canonical_validator_top_test.sv]
// testbench of the acl canonical order validator: directed and random lists vs a predictor
`timescale 1ns / 100ps

module acl_canonical_validator_top_test;
    import acv_pkg::*;

    localparam int MAX_ENTRIES  = 32;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_WORDS = 1110;
    localparam int MAX_REPORTS  = 40;

    // tag codes outside the canonical set
    localparam logic [TAG_W-1:0] TAG_RSVD_A = 3'd6;
    localparam logic [TAG_W-1:0] TAG_RSVD_B = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [TAG_W-1:0]   i_entry_tag;
    logic [PERM_W-1:0]  i_entry_perm;
    logic [ID_W-1:0]    i_entry_id;
    logic               i_last_entry;
    logic               o_valid;
    logic               i_stall;
    logic               o_acl_valid;
    logic [COUNT_W-1:0] o_entry_count;

    // predictor state for the list in progress
    int               acl_len;
    bit               got_owner;
    bit               got_group;
    bit               got_mask;
    bit               got_other;
    bit               got_user;
    bit               got_ngroup;
    logic [ID_W-1:0]  top_uid;
    logic [ID_W-1:0]  top_gid;
    bit               list_bad;

    t_verdict verdict_q[$];
    t_entry   acl_words[$];
    int       mismatches = 0;
    int       sent_words = 0;
    int       verdicts_seen = 0;
    int       quiet = 0;
    bit       calm = 1'b0;

    acl_canonical_validator_top #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_entry_tag  (i_entry_tag),
        .i_entry_perm (i_entry_perm),
        .i_entry_id   (i_entry_id),
        .i_last_entry (i_last_entry),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_acl_valid  (o_acl_valid),
        .o_entry_count(o_entry_count)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    task automatic clear_acl_state();
        acl_len    = 0;
        got_owner  = 1'b0;
        got_group  = 1'b0;
        got_mask   = 1'b0;
        got_other  = 1'b0;
        got_user   = 1'b0;
        got_ngroup = 1'b0;
        top_uid    = '0;
        top_gid    = '0;
        list_bad   = 1'b0;
    endtask

    // order and form rules for one accepted word, verdict on the last one
    task automatic apply_entry(input t_entry e);
        bit       bad;
        t_verdict v;
        bad = (e.perm & ~PERM_ALLOWED) != '0;
        if (!bad) begin
            case (e.tag)
                TAG_OWNER: begin
                    if (got_owner || acl_len != 0) bad = 1'b1;
                    else got_owner = 1'b1;
                end
                TAG_NAMED_USER: begin
                    if (!got_owner || got_group || e.id == UNDEF_ID ||
                        (got_user && e.id <= top_uid)) begin
                        bad = 1'b1;
                    end else begin
                        top_uid  = e.id;
                        got_user = 1'b1;
                    end
                end
                TAG_OWNER_GROUP: begin
                    if (!got_owner || got_group) bad = 1'b1;
                    else got_group = 1'b1;
                end
                TAG_NAMED_GROUP: begin
                    if (!got_group || got_mask || e.id == UNDEF_ID ||
                        (got_ngroup && e.id <= top_gid)) begin
                        bad = 1'b1;
                    end else begin
                        top_gid    = e.id;
                        got_ngroup = 1'b1;
                    end
                end
                TAG_MASK: begin
                    if (got_mask || !got_group) bad = 1'b1;
                    else got_mask = 1'b1;
                end
                TAG_OTHER: begin
                    if (got_other || !got_group || !e.last) bad = 1'b1;
                    else got_other = 1'b1;
                end
                default: bad = 1'b1;
            endcase
        end
        if (bad) list_bad = 1'b1;
        if (acl_len < MAX_ENTRIES + 1) acl_len++;
        if (e.last) begin
            v.acl_valid = !list_bad && acl_len >= MIN_ENTRIES && acl_len <= MAX_ENTRIES &&
                          got_owner && got_group && got_other &&
                          (!(got_user || got_ngroup) || got_mask);
            v.entry_count = COUNT_W'(acl_len);
            verdict_q.push_back(v);
            clear_acl_state();
        end
    endtask

    function automatic t_entry mk(input logic [TAG_W-1:0] tag, input logic [PERM_W-1:0] perm,
                                  input logic [ID_W-1:0] id, input logic last);
        t_entry e;
        e.tag  = tag;
        e.perm = perm;
        e.id   = id;
        e.last = last;
        return e;
    endfunction

    function automatic logic [PERM_W-1:0] rand_perm();
        if ($urandom_range(0, 15) == 0) return PERM_W'($urandom);
        return PERM_W'($urandom_range(0, 7));
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input t_entry e);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_entry_tag  <= e.tag;
        i_entry_perm <= e.perm;
        i_entry_id   <= e.id;
        i_last_entry <= e.last;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        apply_entry(e);
        sent_words++;
        @(negedge i_clk);
    endtask

    task automatic send_acl_words();
        foreach (acl_words[k]) send_word(acl_words[k]);
    endtask

    task automatic drain_verdicts();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (verdict_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic add_named(input logic [TAG_W-1:0] tag, input int n);
        logic [ID_W-1:0] ids[$];
        repeat (n) ids.push_back($urandom);
        ids.sort();
        foreach (ids[k]) acl_words.push_back(mk(tag, rand_perm(), ids[k], 1'b0));
    endtask

    // canonical list with random ids and permissions
    task automatic build_canonical(input int n_users, input int n_groups);
        acl_words.delete();
        acl_words.push_back(mk(TAG_OWNER, rand_perm(), $urandom, 1'b0));
        add_named(TAG_NAMED_USER, n_users);
        acl_words.push_back(mk(TAG_OWNER_GROUP, rand_perm(), $urandom, 1'b0));
        add_named(TAG_NAMED_GROUP, n_groups);
        if (n_users + n_groups != 0 || $urandom_range(0, 1) == 1) begin
            acl_words.push_back(mk(TAG_MASK, rand_perm(), $urandom, 1'b0));
        end
        acl_words.push_back(mk(TAG_OTHER, rand_perm(), $urandom, 1'b1));
    endtask

    task automatic corrupt_list();
        int     pos;
        int     pos2;
        t_entry e;
        pos  = $urandom_range(0, acl_words.size() - 1);
        pos2 = $urandom_range(0, acl_words.size() - 1);
        case ($urandom_range(0, 7))
            0: begin
                e = acl_words[pos];
                acl_words[pos]  = acl_words[pos2];
                acl_words[pos2] = e;
            end
            1: if (acl_words.size() > 1) acl_words.delete(pos);
            2: acl_words.insert(pos, acl_words[pos]);
            3: acl_words[pos].tag = TAG_W'($urandom_range(0, 7));
            4: acl_words[pos].perm = PERM_W'($urandom);
            5: acl_words[pos].id = UNDEF_ID;
            // list runs on into the next one
            6: acl_words[acl_words.size() - 1].last = 1'b0;
            default: acl_words[pos].last = 1'b1;
        endcase
    endtask

    task automatic send_noise();
        t_entry e;
        repeat ($urandom_range(1, 6)) begin
            e = mk(TAG_W'($urandom_range(0, 7)), PERM_W'($urandom),
                   ($urandom_range(0, 7) == 0) ? UNDEF_ID : ID_W'($urandom),
                   $urandom_range(0, 2) == 0);
            send_word(e);
        end
    endtask

    task automatic test_directed_cases();
        acl_words.delete();
        // shortest valid list
        acl_words.push_back(mk(TAG_OWNER, 16'h0000, 32'h0000_0000, 1'b0));
        acl_words.push_back(mk(TAG_OWNER_GROUP, 16'h0007, UNDEF_ID, 1'b0));
        acl_words.push_back(mk(TAG_OTHER, 16'h0007, 32'h0000_0000, 1'b1));
        // every canonical tag, id extremes
        acl_words.push_back(mk(TAG_OWNER, 16'h0007, UNDEF_ID, 1'b0));
        acl_words.push_back(mk(TAG_NAMED_USER, 16'h0001, 32'h0000_0000, 1'b0));
        acl_words.push_back(mk(TAG_NAMED_USER, 16'h0002, 32'hFFFF_FFFE, 1'b0));
        acl_words.push_back(mk(TAG_OWNER_GROUP, 16'h0004, 32'h0000_0000, 1'b0));
        acl_words.push_back(mk(TAG_NAMED_GROUP, 16'h0003, 32'h0000_0000, 1'b0));
        acl_words.push_back(mk(TAG_NAMED_GROUP, 16'h0005, 32'h8000_0000, 1'b0));
        acl_words.push_back(mk(TAG_MASK, 16'h0006, 32'h5555_AAAA, 1'b0));
        acl_words.push_back(mk(TAG_OTHER, 16'h0000, 32'hAAAA_5555, 1'b1));
        // permission bits above bit 2
        acl_words.push_back(mk(TAG_OWNER, 16'hFFFF, 32'h0000_0001, 1'b0));
        acl_words.push_back(mk(TAG_OWNER_GROUP, 16'h0008, 32'h0000_0002, 1'b0));
        acl_words.push_back(mk(TAG_OTHER, 16'h0000, 32'h0000_0003, 1'b1));
        // undefined id on a named user, list ends without other
        acl_words.push_back(mk(TAG_OWNER, 16'h0000, 32'h0000_0000, 1'b0));
        acl_words.push_back(mk(TAG_NAMED_USER, 16'h0000, UNDEF_ID, 1'b0));
        acl_words.push_back(mk(TAG_OWNER_GROUP, 16'h0000, 32'h0000_0000, 1'b1));
        // invalid tag alone makes a list too short
        acl_words.push_back(mk(TAG_RSVD_A, 16'h8000, 32'h0000_0000, 1'b1));
        // invalid tag mid-list, rest still consumed
        acl_words.push_back(mk(TAG_OWNER, 16'h0000, 32'h0000_0000, 1'b0));
        acl_words.push_back(mk(TAG_RSVD_B, 16'h0000, 32'h0000_0000, 1'b0));
        acl_words.push_back(mk(TAG_OWNER_GROUP, 16'h0000, 32'h0000_0000, 1'b0));
        acl_words.push_back(mk(TAG_OTHER, 16'h0000, 32'h0000_0000, 1'b1));
        // other entry that is not the last one
        acl_words.push_back(mk(TAG_OWNER, 16'h0000, 32'h0000_0000, 1'b0));
        acl_words.push_back(mk(TAG_OWNER_GROUP, 16'h0000, 32'h0000_0000, 1'b0));
        acl_words.push_back(mk(TAG_OTHER, 16'h0000, 32'h0000_0000, 1'b0));
        acl_words.push_back(mk(TAG_MASK, 16'h0000, 32'h0000_0000, 1'b1));
        send_acl_words();
    endtask

    // longest valid list, one over, and one far enough over to saturate
    task automatic test_length_limits();
        build_canonical(14, 14);
        send_acl_words();
        build_canonical(15, 14);
        send_acl_words();
        calm = 1'b1;
        build_canonical(20, 16);
        send_acl_words();
        calm = 1'b0;
    endtask

    task automatic test_random_lists();
        int sel;
        int n;
        int stop_at;
        stop_at = sent_words + RANDOM_WORDS;
        while (sent_words < stop_at) begin
            if ($urandom_range(0, 15) == 0) calm = !calm;
            sel = $urandom_range(0, 19);
            if (sel < 14) begin
                build_canonical($urandom_range(0, 3), $urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0) corrupt_list();
                send_acl_words();
            end else if (sel < 16) begin
                send_noise();
            end else if (sel == 16) begin
                n = $urandom_range(26, 34);
                build_canonical(n / 2, n - n / 2);
                if ($urandom_range(0, 3) == 0) corrupt_list();
                send_acl_words();
            end else if (sel == 17) begin
                drain_verdicts();
            end else begin
                build_canonical($urandom_range(0, 2), $urandom_range(0, 2));
                send_acl_words();
            end
        end
        // close whatever list is open
        calm = 1'b0;
        build_canonical(1, 1);
        send_acl_words();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_entry_tag  = '0;
        i_entry_perm = '0;
        i_entry_id   = '0;
        i_last_entry = 1'b0;
        clear_acl_state();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        drain_verdicts();
        test_length_limits();
        test_random_lists();

        drain_verdicts();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("acl_canonical_validator_top verification clean");
        end else begin
            $display("acl_canonical_validator_top verification failed");
        end
        $finish;
    end

    // result side: random stall per verdict word, then compare with the oldest expectation
    initial begin : verdict_checker
        int       hold;
        t_verdict want;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 11);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("verdict %0d arrived with none expected",
                                          verdicts_seen));
            end else begin
                want = verdict_q.pop_front();
                if (o_acl_valid !== want.acl_valid) begin
                    report_mismatch($sformatf("verdict %0d: acl_valid %b, expected %b",
                                              verdicts_seen, o_acl_valid, want.acl_valid));
                end
                if (o_entry_count !== want.entry_count) begin
                    report_mismatch($sformatf("verdict %0d: entry_count %0d, expected %0d",
                                              verdicts_seen, o_entry_count,
                                              want.entry_count));
                end
            end
            @(negedge i_clk);
        end
    end

    // stop a hung run: count cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("acl_canonical_validator_top verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule
